// File: rtl/rlbc_pkg.sv
// ----------------------------------------------------------------------------
// rlbc_pkg
// shared widths, codes and reset values of the rgb lamp breathing controller
// ----------------------------------------------------------------------------
package rlbc_pkg;

  localparam int unsigned LightW = 12;
  localparam int unsigned DelayW = 7;
  localparam int unsigned TickW  = 9;
  localparam int unsigned PwmW   = 8;
  localparam int unsigned PresW  = 2;
  localparam int unsigned StepW  = 2;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned LedW   = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  typedef logic [LightW-1:0]   light_t;
  typedef logic [DelayW-1:0]   delay_t;
  typedef logic [TickW-1:0]    tick_t;
  typedef logic [PwmW-1:0]     pwm_t;
  typedef logic [PresW-1:0]    pres_t;
  typedef logic [StepW-1:0]    step_t;
  typedef logic [ModeW-1:0]    mode_t;
  typedef logic [LedW-1:0]     led_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_OFF_THRESHOLD     = 3'd0;
  localparam cfg_idx_t CFG_RESTORE_THRESHOLD = 3'd1;
  localparam cfg_idx_t CFG_RESTORE_DELAY     = 3'd2;
  localparam cfg_idx_t CFG_TICKS_PER_TASK    = 3'd3;
  localparam cfg_idx_t CFG_PWM_PERIOD        = 3'd4;
  localparam cfg_idx_t CFG_DUTY_PRESCALE     = 3'd5;
  localparam cfg_idx_t CFG_DUTY_TOP          = 3'd6;

  // configuration reset values
  localparam light_t RST_OFF_THRESHOLD     = 12'd2048;
  localparam light_t RST_RESTORE_THRESHOLD = 12'd1638;
  localparam delay_t RST_RESTORE_DELAY     = 7'd100;
  localparam tick_t  RST_TICKS_PER_TASK    = 9'd400;
  localparam pwm_t   RST_PWM_PERIOD        = 8'd200;
  localparam pres_t  RST_DUTY_PRESCALE     = 2'd3;
  localparam pwm_t   RST_DUTY_TOP          = 8'd203;

  // lamp modes
  localparam mode_t MODE_WHITE  = 3'd0;
  localparam mode_t MODE_RED    = 3'd1;
  localparam mode_t MODE_GREEN  = 3'd2;
  localparam mode_t MODE_BLUE   = 3'd3;
  localparam mode_t MODE_BREATH = 3'd4;
  localparam mode_t MODE_DARK   = 3'd5;

  // fade steps
  localparam step_t STEP_RB   = 2'd0;
  localparam step_t STEP_BG   = 2'd1;
  localparam step_t STEP_GR   = 2'd2;
  localparam step_t STEP_LAST = 2'd3;

  // led drive patterns
  localparam led_t LED_OFF   = 4'b0000;
  localparam led_t LED_WHITE = 4'b0001;
  localparam led_t LED_RED   = 4'b0010;
  localparam led_t LED_GREEN = 4'b0100;
  localparam led_t LED_BLUE  = 4'b1000;

  localparam int unsigned LedWhiteBit = 0;
  localparam int unsigned LedRedBit   = 1;
  localparam int unsigned LedGreenBit = 2;
  localparam int unsigned LedBlueBit  = 3;

endpackage

// File: rtl/rlbc_if.sv
// ----------------------------------------------------------------------------
// rlbc_in_if / rlbc_out_if
// valid/ready channels for tick beats and lamp result beats
// ----------------------------------------------------------------------------
interface rlbc_in_if;
  logic                  valid;
  logic                  ready;
  logic                  key_level;
  rlbc_pkg::light_t      light_level;

  modport source (output valid, output key_level, output light_level, input ready);
  modport sink   (input valid, input key_level, input light_level, output ready);
endinterface

interface rlbc_out_if;
  logic                  valid;
  logic                  ready;
  logic                  led_white;
  logic                  led_red;
  logic                  led_green;
  logic                  led_blue;
  rlbc_pkg::mode_t       lamp_mode;

  modport source (output valid, output led_white, output led_red, output led_green,
                  output led_blue, output lamp_mode, input ready);
  modport sink   (input valid, input led_white, input led_red, input led_green,
                  input led_blue, input lamp_mode, output ready);
endinterface

// File: rtl/rgb_lamp_breathing_controller_unit.sv
// ----------------------------------------------------------------------------
// rgb_lamp_breathing_controller_unit
// per-tick breathing pwm, light check, key mode cycling and mode apply
// ----------------------------------------------------------------------------
// path: an accepted tick beat goes into the input register, then the state
// update writes its result into the result register
// throughput: one beat per cycle while the lamp side does not stall
// reset: counters and modes cleared, update pending set, leds off,
// configuration registers back to their default values
module rgb_lamp_breathing_controller_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  rlbc_pkg::cfg_idx_t  cfg_idx_i,
  input  rlbc_pkg::cfg_data_t cfg_data_i,
  rlbc_in_if.sink             in_if,
  rlbc_out_if.source          out_if
);
  import rlbc_pkg::*;

  // configuration
  light_t off_thr_q, restore_thr_q;
  delay_t restore_delay_q;
  tick_t  ticks_per_task_q;
  pwm_t   pwm_period_q, duty_top_q;
  pres_t  duty_prescale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_thr_q        <= RST_OFF_THRESHOLD;
      restore_thr_q    <= RST_RESTORE_THRESHOLD;
      restore_delay_q  <= RST_RESTORE_DELAY;
      ticks_per_task_q <= RST_TICKS_PER_TASK;
      pwm_period_q     <= RST_PWM_PERIOD;
      duty_prescale_q  <= RST_DUTY_PRESCALE;
      duty_top_q       <= RST_DUTY_TOP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OFF_THRESHOLD:     off_thr_q        <= cfg_data_i[LightW-1:0];
        CFG_RESTORE_THRESHOLD: restore_thr_q    <= cfg_data_i[LightW-1:0];
        CFG_RESTORE_DELAY:     restore_delay_q  <= cfg_data_i[DelayW-1:0];
        CFG_TICKS_PER_TASK:    ticks_per_task_q <= cfg_data_i[TickW-1:0];
        CFG_PWM_PERIOD:        pwm_period_q     <= cfg_data_i[PwmW-1:0];
        CFG_DUTY_PRESCALE:     duty_prescale_q  <= cfg_data_i[PresW-1:0];
        CFG_DUTY_TOP:          duty_top_q       <= cfg_data_i[PwmW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic   in_vld_q, out_vld_q;
  logic   key_q;
  light_t light_q;
  logic   s1_move, in_take;

  assign s1_move     = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || s1_move;
  assign in_take     = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_if.ready) in_vld_q <= in_if.valid;
      if (!out_vld_q || out_if.ready) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      key_q   <= in_if.key_level;
      light_q <= in_if.light_level;
    end
  end

  // lamp state
  tick_t  tick_q, tick_d;
  pwm_t   pwm_q, pwm_d, duty_q, duty_d;
  pres_t  pres_q, pres_d;
  step_t  step_q, step_d;
  mode_t  mode_q, mode_d, saved_q, saved_d;
  delay_t dark_q, dark_d;
  led_t   led_q, led_d;
  logic   key_held_q, key_held_d, pend_q, pend_d;
  logic   breath_q, breath_d, bright_q, bright_d;
  logic   task_hit;

  always_comb begin
    tick_d     = tick_q + 1'b1;
    pwm_d      = pwm_q;
    duty_d     = duty_q;
    pres_d     = pres_q;
    step_d     = step_q;
    mode_d     = mode_q;
    saved_d    = saved_q;
    dark_d     = dark_q;
    led_d      = led_q;
    key_held_d = key_held_q;
    pend_d     = pend_q;
    breath_d   = breath_q;
    bright_d   = bright_q;

    task_hit = (tick_d >= ticks_per_task_q);
    if (task_hit) tick_d = '0;

    // breathing engine
    if (breath_q) begin
      pwm_d = pwm_q + 1'b1;
      if (pwm_d >= pwm_period_q) begin
        pwm_d  = '0;
        pres_d = pres_q + 1'b1;
        if (pres_d >= duty_prescale_q) begin
          pres_d = '0;
          duty_d = duty_q + 1'b1;
        end
        if (duty_d > duty_top_q) begin
          duty_d = '0;
          step_d = step_q + 1'b1;
          if (step_d == STEP_LAST) step_d = STEP_RB;
        end
      end
      if (duty_d <= pwm_d) begin
        case (step_d)
          STEP_RB: led_d = LED_RED;
          STEP_BG: led_d = LED_BLUE;
          STEP_GR: led_d = LED_GREEN;
          default: ;
        endcase
      end else begin
        case (step_d)
          STEP_RB: led_d = LED_BLUE;
          STEP_BG: led_d = LED_GREEN;
          STEP_GR: led_d = LED_RED;
          default: ;
        endcase
      end
    end

    if (task_hit) begin
      // light check
      if (light_q >= off_thr_q && !bright_q) begin
        bright_d = 1'b1;
        mode_d   = MODE_DARK;
        pend_d   = 1'b1;
        dark_d   = '0;
      end else if (light_q <= restore_thr_q && bright_q) begin
        dark_d = dark_q + 1'b1;
        if (dark_d >= restore_delay_q) begin
          bright_d = 1'b0;
          mode_d   = saved_q;
          pend_d   = 1'b1;
          dark_d   = '0;
        end
      end

      // key check
      if (!bright_d) begin
        if (!key_q && !key_held_q) begin
          key_held_d = 1'b1;
          pend_d     = 1'b1;
          mode_d     = mode_d + 1'b1;
          if (mode_d > MODE_BREATH) mode_d = MODE_WHITE;
          saved_d    = mode_d;
        end else if (key_q) begin
          key_held_d = 1'b0;
        end
      end

      // mode apply
      if (pend_d) begin
        pend_d   = 1'b0;
        pres_d   = '0;
        step_d   = STEP_RB;
        pwm_d    = '0;
        duty_d   = '0;
        breath_d = (mode_d == MODE_BREATH);
        case (mode_d)
          MODE_WHITE: led_d = LED_WHITE;
          MODE_RED:   led_d = LED_RED;
          MODE_GREEN: led_d = LED_GREEN;
          MODE_BLUE:  led_d = LED_BLUE;
          MODE_DARK:  led_d = LED_OFF;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      pwm_q      <= '0;
      duty_q     <= '0;
      pres_q     <= '0;
      step_q     <= STEP_RB;
      mode_q     <= MODE_WHITE;
      saved_q    <= MODE_WHITE;
      dark_q     <= '0;
      led_q      <= LED_OFF;
      key_held_q <= 1'b0;
      pend_q     <= 1'b1;
      breath_q   <= 1'b0;
      bright_q   <= 1'b0;
    end else if (s1_move) begin
      tick_q     <= tick_d;
      pwm_q      <= pwm_d;
      duty_q     <= duty_d;
      pres_q     <= pres_d;
      step_q     <= step_d;
      mode_q     <= mode_d;
      saved_q    <= saved_d;
      dark_q     <= dark_d;
      led_q      <= led_d;
      key_held_q <= key_held_d;
      pend_q     <= pend_d;
      breath_q   <= breath_d;
      bright_q   <= bright_d;
    end
  end

  // result register
  led_t  res_led_q;
  mode_t res_mode_q;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      res_led_q  <= led_d;
      res_mode_q <= mode_d;
    end
  end

  assign out_if.valid     = out_vld_q;
  assign out_if.led_white = res_led_q[LedWhiteBit];
  assign out_if.led_red   = res_led_q[LedRedBit];
  assign out_if.led_green = res_led_q[LedGreenBit];
  assign out_if.led_blue  = res_led_q[LedBlueBit];
  assign out_if.lamp_mode = res_mode_q;

endmodule

// File: verif/rlbc_lamp_checker.sv
// ----------------------------------------------------------------------------
// rlbc_lamp_checker
// watches the tick and lamp channels and the register port, keeps its own
// copy of the breathing engine, light check, key cycling and mode apply, and
// compares every lamp beat field by field with the oldest predicted beat
// ----------------------------------------------------------------------------
module rlbc_lamp_checker
  import rlbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  cfg_idx_t    cfg_idx_i,
  input  cfg_data_t   cfg_data_i,
  rlbc_in_if          in_if,
  rlbc_out_if         out_if,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic  white;
    logic  red;
    logic  green;
    logic  blue;
    mode_t mode;
  } lamp_beat_t;

  lamp_beat_t  pending_lamps [$];
  int unsigned fails = 0;

  light_t off_thr, restore_thr;
  delay_t restore_dly;
  tick_t  task_ticks;
  pwm_t   pwm_per, duty_top;
  pres_t  duty_pres;

  tick_t  tick_cnt;
  pwm_t   pwm_cnt, duty;
  pres_t  pres_cnt;
  step_t  step;
  mode_t  cur_mode, saved_mode;
  delay_t dark_cnt;
  led_t   leds;
  logic   key_held, upd_pending, breathing, bright;

  task automatic advance_lamp(input logic key, input light_t lt);
    logic task_due;
    task_due = 1'b0;
    tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt >= task_ticks) begin
      tick_cnt = '0;
      task_due = 1'b1;
    end
    if (breathing) begin
      pwm_cnt = pwm_cnt + 1'b1;
      if (pwm_cnt >= pwm_per) begin
        pwm_cnt  = '0;
        pres_cnt = pres_cnt + 1'b1;
        if (pres_cnt >= duty_pres) begin
          pres_cnt = '0;
          duty     = duty + 1'b1;
        end
        if (duty > duty_top) begin
          duty = '0;
          step = step + 1'b1;
          if (step >= STEP_LAST) step = STEP_RB;
        end
      end
      if (duty <= pwm_cnt) begin
        case (step)
          STEP_RB: leds = LED_RED;
          STEP_BG: leds = LED_BLUE;
          STEP_GR: leds = LED_GREEN;
          default: ;
        endcase
      end else begin
        case (step)
          STEP_RB: leds = LED_BLUE;
          STEP_BG: leds = LED_GREEN;
          STEP_GR: leds = LED_RED;
          default: ;
        endcase
      end
    end
    if (task_due) begin
      if (lt >= off_thr && !bright) begin
        bright      = 1'b1;
        cur_mode    = MODE_DARK;
        upd_pending = 1'b1;
        dark_cnt    = '0;
      end else if (lt <= restore_thr && bright) begin
        dark_cnt = dark_cnt + 1'b1;
        if (dark_cnt >= restore_dly) begin
          bright      = 1'b0;
          cur_mode    = saved_mode;
          upd_pending = 1'b1;
          dark_cnt    = '0;
        end
      end
      if (!bright) begin
        if (!key && !key_held) begin
          key_held    = 1'b1;
          upd_pending = 1'b1;
          cur_mode    = cur_mode + 1'b1;
          if (cur_mode > MODE_BREATH) cur_mode = MODE_WHITE;
          saved_mode  = cur_mode;
        end else if (key) begin
          key_held = 1'b0;
        end
      end
      if (upd_pending) begin
        upd_pending = 1'b0;
        pres_cnt    = '0;
        step        = STEP_RB;
        pwm_cnt     = '0;
        duty        = '0;
        breathing   = (cur_mode == MODE_BREATH);
        case (cur_mode)
          MODE_WHITE: leds = LED_WHITE;
          MODE_RED:   leds = LED_RED;
          MODE_GREEN: leds = LED_GREEN;
          MODE_BLUE:  leds = LED_BLUE;
          MODE_DARK:  leds = LED_OFF;
          default: ;
        endcase
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lamp_beat_t want, got;
    if (!rst_ni) begin
      off_thr     = RST_OFF_THRESHOLD;
      restore_thr = RST_RESTORE_THRESHOLD;
      restore_dly = RST_RESTORE_DELAY;
      task_ticks  = RST_TICKS_PER_TASK;
      pwm_per     = RST_PWM_PERIOD;
      duty_pres   = RST_DUTY_PRESCALE;
      duty_top    = RST_DUTY_TOP;
      tick_cnt    = '0;
      pwm_cnt     = '0;
      pres_cnt    = '0;
      duty        = '0;
      step        = STEP_RB;
      cur_mode    = MODE_WHITE;
      saved_mode  = MODE_WHITE;
      dark_cnt    = '0;
      leds        = LED_OFF;
      key_held    = 1'b0;
      upd_pending = 1'b1;
      breathing   = 1'b0;
      bright      = 1'b0;
      pending_lamps.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OFF_THRESHOLD:     off_thr     = light_t'(cfg_data_i);
          CFG_RESTORE_THRESHOLD: restore_thr = light_t'(cfg_data_i);
          CFG_RESTORE_DELAY:     restore_dly = delay_t'(cfg_data_i);
          CFG_TICKS_PER_TASK:    task_ticks  = tick_t'(cfg_data_i);
          CFG_PWM_PERIOD:        pwm_per     = pwm_t'(cfg_data_i);
          CFG_DUTY_PRESCALE:     duty_pres   = pres_t'(cfg_data_i);
          CFG_DUTY_TOP:          duty_top    = pwm_t'(cfg_data_i);
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.led_white, out_if.led_red, out_if.led_green, out_if.led_blue,
                out_if.lamp_mode};
        if (pending_lamps.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("lamp beat with none predicted: w%0b r%0b g%0b b%0b mode %0d",
                     got.white, got.red, got.green, got.blue, got.mode);
        end else begin
          want = pending_lamps.pop_front();
          if (want !== got) begin
            fails++;
            if (fails <= 10)
              $display("lamp beat mismatch: want %b%b%b%b mode %0d, got %b%b%b%b mode %0d",
                       want.white, want.red, want.green, want.blue, want.mode,
                       got.white, got.red, got.green, got.blue, got.mode);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        advance_lamp(in_if.key_level, in_if.light_level);
        pending_lamps.push_back('{leds[LedWhiteBit], leds[LedRedBit], leds[LedGreenBit],
                                  leds[LedBlueBit], cur_mode});
      end
    end
    fail_count_o <= fails;
    pending_o    <= pending_lamps.size();
  end

endmodule

// File: verif/tb_rgb_lamp_breathing_controller_unit.sv
// ----------------------------------------------------------------------------
// tb_rgb_lamp_breathing_controller_unit
// drives tick beats through a series of register settings: a short directed
// walk through modes, light off and restore, then random key presses and
// light runs, with random idling on both channels and one long output stall
// ----------------------------------------------------------------------------
module tb_rgb_lamp_breathing_controller_unit;
  import rlbc_pkg::*;

  localparam int unsigned NumPhases    = 8;
  localparam int unsigned NumRegs      = 7;
  localparam int unsigned NumDirected  = 25;
  localparam int unsigned HoldPhase    = 4;
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned TimeoutUnits = 6000000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  cfg_idx_t    cfg_idx_i;
  cfg_data_t   cfg_data_i;
  int unsigned fail_count, pending, odds;
  logic        hold_req;

  // register values per phase, in register index order
  int unsigned phase_cfg [NumPhases][NumRegs] = '{
    '{2048, 1638,   1,   1,   1, 1,   1},
    '{2048, 1638,   1,   2,   4, 1,   3},
    '{   0, 4095,   0,   0,   0, 0,   0},
    '{4095,    0, 127,   1,   1, 3, 254},
    '{1500, 1000,   3,   3,   3, 2,  10},
    '{2048, 1638, 100, 511, 255, 3, 255},
    '{3000,  500,   5,   1,   2, 1, 255},
    '{2048, 1638,   2,   1,   6, 3,   5}
  };
  int unsigned phase_items [NumPhases] = '{NumDirected, 400, 80, 150, 400, 150, 300, 450};
  int unsigned phase_odds  [NumPhases] = '{6, 8, 5, 0, 8, 10, 4, 0};

  bit     dir_key   [NumDirected] = '{1, 0, 0, 1, 0, 1, 0, 1, 0, 1, 1, 1, 1,
                                      1, 0, 1, 0, 1, 1, 0, 0, 1, 0, 1, 0};
  light_t dir_light [NumDirected] = '{0, 0, 100, 100, 1638, 2047, 2000, 0, 0, 0, 0, 0, 0,
                                      4095, 4095, 1639, 1638, 2048, 0, 0, 4095, 0, 0, 0, 0};

  rlbc_in_if  in_if ();
  rlbc_out_if out_if ();

  rgb_lamp_breathing_controller_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  rlbc_lamp_checker u_lamp_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_if        (in_if),
    .out_if       (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #(TimeoutUnits);
    $display("TB_ERROR");
    $finish;
  end

  // lamp side: random stalls, one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (odds != 0 && $urandom_range(0, odds - 1) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_tick(input logic k, input light_t lt);
    if (odds != 0 && $urandom_range(0, odds - 1) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.key_level   <= k;
    in_if.light_level <= lt;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  task automatic settle_and_configure(input int unsigned p);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    for (int r = 0; r < NumRegs; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_t'(r);
      cfg_data_i <= cfg_data_t'(phase_cfg[p][r]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned tpt, off_lvl, rst_lvl, key_run, light_run, cls, press_max;
    logic        key_now, k;
    light_t      lt;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_OFF_THRESHOLD;
    cfg_data_i        <= '0;
    in_if.valid       <= 1'b0;
    in_if.key_level   <= 1'b1;
    in_if.light_level <= '0;
    hold_req          <= 1'b0;
    odds      = 0;
    key_now   = 1'b1;
    key_run   = 0;
    light_run = 0;
    cls       = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned p = 0; p < NumPhases; p++) begin
      settle_and_configure(p);
      odds = phase_odds[p];
      if (p == HoldPhase) hold_req <= 1'b1;
      if (p == 0) begin
        for (int i = 0; i < NumDirected; i++) send_tick(dir_key[i], dir_light[i]);
      end else begin
        tpt       = phase_cfg[p][CFG_TICKS_PER_TASK];
        off_lvl   = phase_cfg[p][CFG_OFF_THRESHOLD];
        rst_lvl   = phase_cfg[p][CFG_RESTORE_THRESHOLD];
        press_max = (2 * tpt + 2 > 60) ? 60 : 2 * tpt + 2;
        for (int unsigned n = 0; n < phase_items[p]; n++) begin
          // long releases with short presses, plus a little key bounce
          if (key_run == 0) begin
            key_now = ~key_now;
            key_run = key_now ? $urandom_range(1, 150) : $urandom_range(1, press_max);
          end
          key_run--;
          k = key_now ^ ($urandom_range(0, 19) == 0);
          // light comes in runs: bright, dark, between thresholds or anything
          if (light_run == 0) begin
            cls       = $urandom_range(0, 9);
            light_run = $urandom_range(1, 40);
          end
          light_run--;
          if (cls < 2)
            lt = light_t'($urandom_range(4095, off_lvl));
          else if (cls < 6)
            lt = light_t'($urandom_range(rst_lvl, 0));
          else if (cls < 8 && off_lvl > rst_lvl + 1)
            lt = light_t'($urandom_range(off_lvl - 1, rst_lvl + 1));
          else
            lt = light_t'($urandom_range(4095, 0));
          send_tick(k, lt);
        end
      end
      in_if.valid <= 1'b0;
    end

    @(posedge clk_i);
    for (int w = 0; w < 2000 && pending != 0; w++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/rlbc_pkg.sv
rtl/rlbc_if.sv
rtl/rgb_lamp_breathing_controller_unit.sv
verif/rlbc_lamp_checker.sv
verif/tb_rgb_lamp_breathing_controller_unit.sv
